/* hw/rtl/pfx_pkg.sv */
// Shared constants, codes and inter-module types of the postfix evaluator.
package pfx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int SYM_W       = 8;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    // ASCII codes recognized by the decoder.
    localparam logic [SYM_W-1:0] CH_0     = 8'h30;
    localparam logic [SYM_W-1:0] CH_9     = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_NEGEXP    = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } op_t;

    typedef struct packed {
        logic                   start;
        op_t                    op;
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] result;
    } alu_rsp_t;

endpackage

/* hw/rtl/pfx_if.sv */
// Valid/ready channel interfaces for incoming symbols and outgoing results.
interface pfx_sym_if;
    import pfx_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             end_of_expression;

    modport source (output valid, output symbol, output end_of_expression, input ready);
    modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

interface pfx_res_if;
    import pfx_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [2:0]                    status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

/* hw/rtl/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator: decoder, stack control and result register.
//
//  Channel   Dir  Payload                          Word accepted when
//  symbols   in   symbol[7:0], end_of_expression   symbols.valid && symbols.ready
//  results   out  value[31:0] signed, status[2:0]  results.valid && results.ready
//
// Digits and ignored characters are handled on acceptance alone; + - * pass through
// accept, operand read from the stack memory and ALU; / runs the 32-step radix-2
// divider; ^ runs the square-and-multiply loop on the shared multiplier, with a multiply
// step and a square step per significant exponent bit. The last word of an
// expression then moves to S_FIN to load the result register, and waits there while
// the previous result has not been taken. Reset empties the stack and clears the error;
// the memory itself is never cleared, since only entries below the fill count are read.
module postfix_expression_evaluator (
    input  logic      clk,
    input  logic      rst_n,
    pfx_sym_if.sink   symbols,
    pfx_res_if.source results
);
    import pfx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    status_t                err_reg, err_next;
    logic [VALUE_WIDTH-1:0] top_reg, top_next;
    op_t                    op_reg, op_next;
    logic                   last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    status_t                out_status_reg, out_status_next;

    logic                   accept;
    logic                   is_digit, is_op;
    op_t                    sym_op;
    logic [SYM_W-1:0]       sym_off;
    logic [VALUE_WIDTH-1:0] digit_val;
    logic [COUNT_W-1:0]     count_m1, count_m2;
    logic                   load_result;
    status_t                final_status;

    logic                   wr_en, rd_en;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;

    // The top of stack lives in top_reg; the memory holds the entries beneath it,
    // so an operator needs only one memory read for its left operand.
    pfx_stack_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfx_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign symbols.ready = (state_reg == S_IDLE);
    assign accept        = symbols.valid && symbols.ready;

    // Symbol decode.
    assign sym_off   = symbols.symbol - CH_0;
    assign digit_val = VALUE_WIDTH'(sym_off[3:0]);
    assign is_digit  = (symbols.symbol >= CH_0) && (symbols.symbol <= CH_9);

    always_comb
    begin
        is_op  = 1'b1;
        sym_op = OP_ADD;
        case (symbols.symbol)
            CH_PLUS:  sym_op = OP_ADD;
            CH_MINUS: sym_op = OP_SUB;
            CH_STAR:  sym_op = OP_MUL;
            CH_SLASH: sym_op = OP_DIV;
            CH_CARET: sym_op = OP_POW;
            default:  is_op  = 1'b0;
        endcase
    end

    assign count_m1 = count_reg - COUNT_W'(1);
    assign count_m2 = count_reg - COUNT_W'(2);

    // A push spills the old top into the memory; an operator fetches the entry below it.
    assign wr_en   = accept && (err_reg == ST_OK) && is_digit && (count_reg != '0)
                     && (count_reg != COUNT_W'(STACK_DEPTH));
    assign wr_addr = count_m1[ADDR_W-1:0];
    assign rd_en   = accept && (err_reg == ST_OK) && is_op && (count_reg >= COUNT_W'(2));
    assign rd_addr = count_m2[ADDR_W-1:0];

    assign alu_req.start = (state_reg == S_READ) && (err_next == ST_OK);
    assign alu_req.op    = op_reg;
    assign alu_req.a     = rd_data;
    assign alu_req.b     = top_reg;

    // A result slot frees up in the same cycle the sink takes the old word.
    assign load_result = (state_reg == S_FIN) && (!out_valid_reg || results.ready);

    always_comb
    begin
        if (err_reg != ST_OK)
        begin
            final_status = err_reg;
        end
        else if (count_reg == '0)
        begin
            final_status = ST_UNDERFLOW;
        end
        else
        begin
            final_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        top_next        = top_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next  = symbols.end_of_expression;
                    state_next = symbols.end_of_expression ? S_FIN : S_IDLE;
                    // After an error the rest of the expression is skipped.
                    if (err_reg == ST_OK)
                    begin
                        if (is_digit)
                        begin
                            if (count_reg == COUNT_W'(STACK_DEPTH))
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                top_next   = digit_val;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        else if (is_op)
                        begin
                            if (count_reg < COUNT_W'(2))
                            begin
                                err_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                op_next    = sym_op;
                                state_next = S_READ;
                            end
                        end
                    end
                end
            end
            S_READ:
            begin
                // Operand checks happen before the ALU starts; the operands stay put.
                if ((op_reg == OP_DIV) && (top_reg == '0))
                begin
                    err_next   = ST_DIVZERO;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
                else if ((op_reg == OP_POW) && top_reg[VALUE_WIDTH-1])
                begin
                    err_next   = ST_NEGEXP;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    top_next   = alu_rsp.result;
                    count_next = count_m1;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (load_result)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = final_status;
                    out_value_next  = (final_status == ST_OK) ? top_reg : '0;
                    count_next      = '0;
                    err_next        = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        op_reg         <= op_next;
        last_reg       <= last_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = $signed(out_value_reg);
    assign results.status = out_status_reg;

`ifndef SYNTH
    // The fill count never passes the stack depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STACK_DEPTH))
    else $error("stack count exceeds depth");

    // Reporting a result empties the stack and clears the error.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (count_reg == '0) && (err_reg == ST_OK) && out_valid_reg)
    else $error("stack not cleared after result");

    // The ALU is only started right after the operand read.
    assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> (state_reg == S_READ) && (count_reg >= COUNT_W'(2)))
    else $error("ALU started outside the operand phase");

    // A failed expression reports zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_value_reg == '0))
    else $error("nonzero value with error status");
`endif
endmodule

/* hw/rtl/pfx_stack_ram.sv */
// Operand stack storage: one write port and one registered read port.
module pfx_stack_ram (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [pfx_pkg::ADDR_W-1:0]      wr_addr,
    input  logic [pfx_pkg::VALUE_WIDTH-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [pfx_pkg::ADDR_W-1:0]      rd_addr,
    output logic [pfx_pkg::VALUE_WIDTH-1:0] rd_data
);
    import pfx_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* hw/rtl/pfx_alu.sv */
// Shared arithmetic unit: add, subtract and multiply with no busy state, a radix-2
// restoring divider and a square-and-multiply power loop on one multiplier.
module pfx_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  pfx_pkg::alu_req_t req,
    output pfx_pkg::alu_rsp_t rsp
);
    import pfx_pkg::*;

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_DIV  = 5'b00010,
        A_SIGN = 5'b00100,
        A_PMUL = 5'b01000,
        A_PSQR = 5'b10000
    } alu_state_t;

    alu_state_t             state_reg, state_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] result_reg, result_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] base_reg, base_next;
    logic [VALUE_WIDTH-1:0] exp_reg, exp_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   neg_reg, neg_next;

    logic [VALUE_WIDTH-1:0]   mul_a, mul_b, product;
    logic [VALUE_WIDTH-1:0]   a_abs, b_abs;
    logic [VALUE_WIDTH:0]     rem_sh, diff;

    // The one multiplier serves the multiply operator and both power steps.
    always_comb
    begin
        case (state_reg)
            A_PMUL:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            A_PSQR:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = req.a;
                mul_b = req.b;
            end
        endcase
    end

    // Only the low half of the product is kept, so the values wrap.
    assign product = mul_a * mul_b;

    assign a_abs  = req.a[VALUE_WIDTH-1] ? (~req.a + VALUE_WIDTH'(1)) : req.a;
    assign b_abs  = req.b[VALUE_WIDTH-1] ? (~req.b + VALUE_WIDTH'(1)) : req.b;
    assign rem_sh = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, div_reg};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_ADD:
                        begin
                            result_next = req.a + req.b;
                            done_next   = 1'b1;
                        end
                        OP_SUB:
                        begin
                            result_next = req.a - req.b;
                            done_next   = 1'b1;
                        end
                        OP_MUL:
                        begin
                            result_next = product;
                            done_next   = 1'b1;
                        end
                        OP_DIV:
                        begin
                            quo_next   = a_abs;
                            div_next   = b_abs;
                            rem_next   = '0;
                            step_next  = STEP_W'(VALUE_WIDTH - 1);
                            neg_next   = req.a[VALUE_WIDTH-1] ^ req.b[VALUE_WIDTH-1];
                            state_next = A_DIV;
                        end
                        OP_POW:
                        begin
                            acc_next   = VALUE_WIDTH'(1);
                            base_next  = req.a;
                            exp_next   = req.b;
                            state_next = A_PMUL;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_DIV:
            begin
                // One quotient bit per cycle, most significant first.
                if (!diff[VALUE_WIDTH])
                begin
                    rem_next = diff[VALUE_WIDTH-1:0];
                    quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[VALUE_WIDTH-1:0];
                    quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = A_SIGN;
                end
            end
            A_SIGN:
            begin
                result_next = neg_reg ? (~quo_reg + VALUE_WIDTH'(1)) : quo_reg;
                done_next   = 1'b1;
                state_next  = A_IDLE;
            end
            A_PMUL:
            begin
                // The loop stops as soon as no exponent bits remain.
                if (exp_reg == '0)
                begin
                    result_next = acc_reg;
                    done_next   = 1'b1;
                    state_next  = A_IDLE;
                end
                else
                begin
                    if (exp_reg[0])
                    begin
                        acc_next = product;
                    end
                    state_next = A_PSQR;
                end
            end
            A_PSQR:
            begin
                base_next  = product;
                exp_next   = exp_reg >> 1;
                state_next = A_PMUL;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        step_reg   <= step_next;
        neg_reg    <= neg_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;
endmodule

/* tb/tb_postfix_expression_evaluator.sv */
// Self-checking testbench of the postfix expression evaluator.
module tb_postfix_expression_evaluator;

    import pfx_pkg::*;

    // Pacing of the run. Each side idles with a chance of about IDLE_PCT percent,
    // except while the accepted word count lies in the quiet window.
    localparam int IDLE_PCT     = 23;
    localparam int QUIET_FROM   = 700;
    localparam int QUIET_TO     = 1000;
    localparam int WORD_TARGET  = 1700;
    // The slowest word is a power with a full 31-bit exponent plus the result load,
    // so reaching STALL_LIMIT without any handshake means the block has hung.
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_word_t;

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        status_t                status;
    } eval_result_t;

    logic clk;
    logic rst_n;

    pfx_sym_if sym_ch ();
    pfx_res_if res_ch ();

    postfix_expression_evaluator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_ch),
        .results (res_ch)
    );

    // Words still to be driven, and results that the predictor has computed
    // but the block has not delivered yet.
    sym_word_t    symbol_queue [$];
    eval_result_t expected_results [$];

    // Predictor state: its own operand stack, fill count and sticky error.
    logic [VALUE_WIDTH-1:0] model_stack [STACK_DEPTH];
    int                     model_count;
    status_t                model_error;

    // Scratch buffer used while an expression is built.
    logic [SYM_W-1:0] text [$];

    sym_word_t next_word;
    logic      sym_fired;
    logic      quiet;
    int        words_accepted;
    int        results_checked;
    int        expressions_sent;
    int        mismatches;
    int        stall_cycles;
    int        status_seen [5];

    always #5 clk = ~clk;

    assign quiet = (words_accepted >= QUIET_FROM) && (words_accepted < QUIET_TO);

    function automatic bit is_digit(input logic [SYM_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic bit is_operator(input logic [SYM_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_CARET);
    endfunction

    // Square-and-multiply; everything wraps at the value width.
    function automatic logic [VALUE_WIDTH-1:0] power_of(input logic [VALUE_WIDTH-1:0] base,
                                                         input logic [VALUE_WIDTH-1:0] ex);
        logic [VALUE_WIDTH-1:0] acc;
        logic [VALUE_WIDTH-1:0] sq;
        acc = VALUE_WIDTH'(1);
        sq  = base;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (ex[i])
                acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    // Applies one accepted word to the predictor state. The final word of an
    // expression is processed first; then the top value (or the error) is
    // queued as the expected result and the stack is emptied.
    task automatic evaluate_symbol(input logic [SYM_W-1:0] sym, input logic last);
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
        logic [VALUE_WIDTH-1:0] r;
        logic [VALUE_WIDTH-1:0] mag_a;
        logic [VALUE_WIDTH-1:0] mag_b;
        bit                     applied;
        eval_result_t           res;
        applied = 1'b1;
        r       = '0;
        if (model_error == ST_OK)
        begin
            if (is_digit(sym))
            begin
                if (model_count >= STACK_DEPTH)
                    model_error = ST_OVERFLOW;
                else
                begin
                    model_stack[model_count] = VALUE_WIDTH'(sym - CH_0);
                    model_count++;
                end
            end
            else if (is_operator(sym))
            begin
                if (model_count < 2)
                    model_error = ST_UNDERFLOW;
                else
                begin
                    b = model_stack[model_count - 1];
                    a = model_stack[model_count - 2];
                    case (sym)
                        CH_PLUS:  r = a + b;
                        CH_MINUS: r = a - b;
                        CH_STAR:  r = a * b;
                        CH_SLASH:
                        begin
                            if (b == 0)
                            begin
                                model_error = ST_DIVZERO;
                                applied     = 1'b0;
                            end
                            else
                            begin
                                // Unsigned divide of the magnitudes keeps the most
                                // negative value divided by minus one well defined.
                                mag_a = a[VALUE_WIDTH-1] ? -a : a;
                                mag_b = b[VALUE_WIDTH-1] ? -b : b;
                                r     = mag_a / mag_b;
                                if (a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1])
                                    r = -r;
                            end
                        end
                        default:
                        begin
                            if (b[VALUE_WIDTH-1])
                            begin
                                model_error = ST_NEGEXP;
                                applied     = 1'b0;
                            end
                            else
                                r = power_of(a, b);
                        end
                    endcase
                    if (applied)
                    begin
                        model_count--;
                        model_stack[model_count - 1] = r;
                    end
                end
            end
        end
        if (last)
        begin
            res.status = model_error;
            res.value  = '0;
            if (model_error == ST_OK)
            begin
                if (model_count == 0)
                    res.status = ST_UNDERFLOW;
                else
                    res.value = model_stack[model_count - 1];
            end
            expected_results.push_back(res);
            model_count = 0;
            model_error = ST_OK;
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Moves the scratch buffer into the word queue as one expression, with the
    // end marker on its final character.
    task automatic flush_expression();
        sym_word_t w;
        for (int i = 0; i < text.size(); i++)
        begin
            w.symbol = text[i];
            w.last   = (i == text.size() - 1);
            symbol_queue.push_back(w);
        end
        text.delete();
        expressions_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        flush_expression();
    endtask

    function automatic logic [SYM_W-1:0] filler_char();
        logic [SYM_W-1:0] c;
        do
            c = SYM_W'($urandom_range(255));
        while (is_digit(c) || is_operator(c));
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        case ($urandom_range(4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] random_digit();
        return CH_0 + SYM_W'($urandom_range(9));
    endfunction

    // Appends a well-formed postfix expression with the given number of
    // operands to the scratch buffer, with ignored characters sprinkled in.
    task automatic build_wellformed(input int operands);
        int depth;
        int left;
        depth = 0;
        left  = operands;
        while (left > 0 || depth > 1)
        begin
            if ($urandom_range(99) < 8)
                text.push_back(filler_char());
            if (left > 0 && (depth < 2 || $urandom_range(1) == 0))
            begin
                text.push_back(random_digit());
                depth++;
                left--;
            end
            else
            begin
                text.push_back(random_operator());
                depth--;
            end
        end
        if ($urandom_range(99) < 10)
            text.push_back(filler_char());
    endtask

    // Random part of the stimulus. Most expressions are well formed with random
    // content so that values grow and wrap; the rest aim at the deepest stack, a wrap to
    // the most negative value divided by minus one, the error paths and plain noise.
    task automatic build_random_stimulus();
        int    pick;
        int    n;
        string wrap_seq;
        wrap_seq = "284*1-^01-/";
        while (symbol_queue.size() < WORD_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
                build_wellformed(n);
            end
            else if (pick < 65)
            begin
                // Fill the stack from one short of the brim to beyond it, then a few operators.
                n = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 4);
                repeat (n)
                    text.push_back(random_digit());
                repeat ($urandom_range(3))
                    text.push_back(random_operator());
            end
            else if (pick < 70)
            begin
                // Two to the 31st wraps to the most negative value, which is then
                // divided by minus one.
                for (int i = 0; i < wrap_seq.len(); i++)
                    text.push_back(wrap_seq[i]);
                if ($urandom_range(1))
                    text.push_back(filler_char());
            end
            else if (pick < 82)
            begin
                // Usually an error early on, after which the remaining characters must be ignored.
                case ($urandom_range(3))
                    0: text.push_back(CH_PLUS);
                    1: begin text.push_back(random_digit()); text.push_back(CH_0);
                             text.push_back(CH_SLASH); end
                    2: begin text.push_back(random_digit()); text.push_back(CH_0);
                             text.push_back(random_digit()); text.push_back(CH_MINUS);
                             text.push_back(CH_CARET); end
                    default: build_wellformed($urandom_range(1, 3));
                endcase
                build_wellformed($urandom_range(1, 4));
            end
            else
            begin
                // Noise: any byte at all, meaningful or not.
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(2))
                        0:       text.push_back(random_digit());
                        1:       text.push_back(random_operator());
                        default: text.push_back(SYM_W'($urandom_range(255)));
                    endcase
                end
            end
            flush_expression();
        end
    endtask

    // Driver: a new word is presented at the falling edge once the previous one
    // was taken; the result side's ready is redrawn every cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sym_ch.valid <= 1'b0;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (!sym_ch.valid || sym_fired)
            begin
                if (symbol_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_word                = symbol_queue.pop_front();
                    sym_ch.valid             <= 1'b1;
                    sym_ch.symbol            <= next_word.symbol;
                    sym_ch.end_of_expression <= next_word.last;
                end
                else
                    sym_ch.valid <= 1'b0;
            end
            res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: both handshakes are sampled at the rising edge. An accepted word
    // advances the predictor; an accepted result is checked against the oldest
    // expectation. The watchdog counts cycles in which neither side moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sym_fired <= sym_ch.valid && sym_ch.ready;
            if (sym_ch.valid && sym_ch.ready)
            begin
                evaluate_symbol(sym_ch.symbol, sym_ch.end_of_expression);
                words_accepted++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                    flag_mismatch($sformatf("unexpected result, value %0d status %0d",
                                            res_ch.value, res_ch.status));
                else
                begin
                    if (res_ch.value !== expected_results[0].value)
                        flag_mismatch($sformatf("value expected %0d, got %0d",
                                                $signed(expected_results[0].value),
                                                res_ch.value));
                    if (res_ch.status !== expected_results[0].status)
                        flag_mismatch($sformatf("status expected %0d, got %0d",
                                                expected_results[0].status, res_ch.status));
                    status_seen[expected_results[0].status]++;
                    void'(expected_results.pop_front());
                end
            end
            if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        sym_ch.valid             = 1'b0;
        sym_ch.symbol            = '0;
        sym_ch.end_of_expression = 1'b0;
        res_ch.ready             = 1'b0;
        sym_fired                = 1'b0;
        words_accepted           = 0;
        results_checked          = 0;
        expressions_sent         = 0;
        mismatches               = 0;
        stall_cycles             = 0;
        model_count              = 0;
        model_error              = ST_OK;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed expressions: the smallest digit alone, an operator on an
        // empty stack, an end marker on an empty stack, all four arithmetic
        // operators with truncation toward zero of a negative quotient and the
        // largest digit, zero to the power zero, divide by zero, and a negative
        // exponent.
        add_text("0");
        add_text("+");
        add_text(" ");
        add_text("35-7*4/9+");
        add_text("00^");
        add_text("90/");
        add_text("201-^");
        build_random_stimulus();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All words accepted, then every expected result delivered; the
        // watchdog covers a block that never gets there.
        while (symbol_queue.size() != 0 || sym_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d words in %0d expressions; %0d results checked, %0d mismatches.",
                 words_accepted, expressions_sent, results_checked, mismatches);
        $display("Results by status: ok %0d, underflow %0d, divide by zero %0d, %s %0d, %s %0d.",
                 status_seen[ST_OK], status_seen[ST_UNDERFLOW], status_seen[ST_DIVZERO],
                 "negative exponent", status_seen[ST_NEGEXP],
                 "overflow", status_seen[ST_OVERFLOW]);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
